// ----- src/lui_pkg.sv -----
// shared types, state codes and saturating arithmetic for the 4x4 inverter
`timescale 1ns / 1ps
package lui_pkg;

    localparam int DIM   = 4;
    localparam int NELEM = 16;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] S64_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S64_MIN = -64'sd2147483648;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_CHK,
        ST_F_RD,
        ST_F_LD,
        ST_MAC_RD,
        ST_MAC_MUL,
        ST_MAC_ACC,
        ST_F_WR,
        ST_CMP1,
        ST_CMP2,
        ST_CMP3,
        ST_SW_RD,
        ST_SW_W1,
        ST_SW_W2,
        ST_PIV,
        ST_D_RD,
        ST_D_ST,
        ST_D_WT,
        ST_V_RD,
        ST_V_SW,
        ST_S_FWR,
        ST_B_RD,
        ST_B_LD,
        ST_B_PRD,
        ST_B_DST,
        ST_B_DWT,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

    typedef enum logic [1:0] {
        PH_FAC,
        PH_FWD,
        PH_BWD
    } phase_t;

    typedef struct packed {
        logic              start;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic signed [31:0] q;
    } div_rsp_t;

    typedef struct packed {
        logic              push;
        logic signed [31:0] data;
        logic              singular;
        logic              last;
    } res_word_t;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > S64_MAX)
            r = S32_MAX;
        else if (x < S64_MIN)
            r = S32_MIN;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] d;
        logic signed [31:0] r;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31])
            r = d[32] ? S32_MIN : S32_MAX;
        else
            r = d[31:0];
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

endpackage

// ----- src/lui_if.sv -----
// stream channel interfaces for matrix elements and inverse words
`timescale 1ns / 1ps
interface lui_elem_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] element;

    modport source (output valid, output element, input ready);
    modport sink (input valid, input element, output ready);
endinterface

interface lui_inv_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] inverse_element;
    logic              singular;
    logic              last;

    modport source (output valid, output inverse_element, output singular, output last,
                    input ready);
    modport sink (input valid, input inverse_element, input singular, input last,
                  output ready);
endinterface

// ----- src/lui_div.sv -----
// iterative restoring divider for saturated fixed point quotients
`timescale 1ns / 1ps
module lui_div
    import lui_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int NB = 32 + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);

    logic              busy_reg;
    logic [CW-1:0]     cnt_reg;
    logic [NB-1:0]     num_reg;
    logic [31:0]       den_reg;
    logic [31:0]       rem_reg;
    logic              neg_reg;
    logic              done_reg;
    logic signed [31:0] q_reg;

    logic [32:0] remsh;
    logic        ge;
    logic        hi;

    assign remsh = {rem_reg, num_reg[NB-1]};
    assign ge    = remsh >= {1'b0, den_reg};
    assign hi    = |num_reg[NB-1:32];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                if (req.b == 32'sd0)
                    done_reg <= 1'b1;
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CW'(NB);
                end
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= {mag32(req.a), {FRAC_BITS{1'b0}}};
            den_reg <= mag32(req.b);
            rem_reg <= '0;
            neg_reg <= req.a[31] ^ req.b[31];
            // divide by zero saturates by the sign of the dividend
            if (req.a[31])
                q_reg <= S32_MIN;
            else if (req.a == 32'sd0)
                q_reg <= 32'sd0;
            else
                q_reg <= S32_MAX;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                if (neg_reg)
                    q_reg <= (hi || (num_reg[31] && |num_reg[30:0])) ? S32_MIN
                                                                     : -num_reg[31:0];
                else
                    q_reg <= (hi || num_reg[31]) ? S32_MAX : num_reg[31:0];
            end
            else
            begin
                rem_reg <= ge ? 32'(remsh - {1'b0, den_reg}) : remsh[31:0];
                num_reg <= {num_reg[NB-2:0], ge};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

endmodule

// ----- src/lui_core.sv -----
// sequencer with factor and solution memories and the shared multiplier
`timescale 1ns / 1ps
module lui_core
    import lui_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_acc,
    input  logic signed [31:0] in_element,
    output logic              load_rdy,
    input  logic              out_free,
    output res_word_t         res,
    output div_req_t          dreq,
    input  div_rsp_t          drsp
);
    localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] BIAS = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    state_t state_reg, state_next;
    phase_t phase_reg;

    logic [3:0]  n_reg;
    logic [1:0]  j_reg, i_reg, k_reg, kmax_reg, r_reg, best_reg;
    logic [1:0]  perm_reg [DIM];
    logic [31:0] rowmax_reg [DIM];
    logic signed [31:0] s_reg, bestval_reg;
    logic [63:0] hold_reg;
    logic signed [65:0] preg;
    logic        sing_reg;

    // factor memory holds the transposed matrix, solution memory the inverse rows
    logic signed [31:0] tmem [NELEM];
    logic signed [31:0] vmem [NELEM];
    logic signed [31:0] t_rda, t_rdb, v_rda, v_rdb;
    logic        t_we, v_we;
    logic [3:0]  t_wa, t_raa, t_rab, v_wa, v_raa, v_rab;
    logic signed [31:0] t_wd, v_wd;

    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;
    logic signed [63:0] pq;
    logic signed [31:0] acc;
    logic [1:0]  kmin, best_eff, best_cmp;
    logic        mac_last, ge, zero_row;
    logic [31:0] in_mag;

    always_ff @(posedge clk)
    begin
        if (t_we)
            tmem[t_wa] <= t_wd;
        t_rda <= tmem[t_raa];
        t_rdb <= tmem[t_rab];
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
            vmem[v_wa] <= v_wd;
        v_rda <= vmem[v_raa];
        v_rdb <= vmem[v_rab];
    end

    assign kmin     = (i_reg < j_reg) ? i_reg : j_reg;
    assign best_eff = (i_reg == j_reg) ? j_reg : best_reg;
    assign best_cmp = ge ? i_reg : best_reg;
    assign mac_last = (phase_reg == PH_BWD) ? (k_reg == 2'd3) : (k_reg == kmax_reg - 2'd1);
    assign ge       = hold_reg >= preg[63:0];
    assign zero_row = (rowmax_reg[0] == '0) || (rowmax_reg[1] == '0)
                   || (rowmax_reg[2] == '0) || (rowmax_reg[3] == '0);
    assign in_mag   = mag32(in_element);

    // product truncated toward zero, then saturated
    assign prod = ma * mb;
    assign pq   = ($signed(preg[63:0]) + (preg[63] ? BIAS : 64'sd0)) >>> FRAC_BITS;
    assign acc  = sat_sub(s_reg, sat64(pq));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:    if (in_acc && n_reg == 4'd15) state_next = ST_CHK;
            ST_CHK:     state_next = zero_row ? ST_OUT_RD : ST_F_RD;
            ST_F_RD:    state_next = ST_F_LD;
            ST_F_LD:    state_next = (kmin == 2'd0) ? ST_F_WR : ST_MAC_RD;
            ST_MAC_RD:  state_next = ST_MAC_MUL;
            ST_MAC_MUL: state_next = ST_MAC_ACC;
            ST_MAC_ACC:
            begin
                if (!mac_last)
                    state_next = ST_MAC_RD;
                else
                    unique case (phase_reg)
                        PH_FAC:  state_next = ST_F_WR;
                        PH_FWD:  state_next = ST_S_FWR;
                        PH_BWD:  state_next = ST_B_PRD;
                        default: state_next = ST_F_WR;
                    endcase
            end
            ST_F_WR:
            begin
                if (i_reg > j_reg)
                    state_next = ST_CMP1;
                else if (i_reg == 2'd3)
                    state_next = (best_eff == j_reg) ? ST_PIV : ST_SW_RD;
                else
                    state_next = ST_F_RD;
            end
            ST_CMP1:    state_next = ST_CMP2;
            ST_CMP2:    state_next = ST_CMP3;
            ST_CMP3:
            begin
                if (i_reg == 2'd3)
                    state_next = (best_cmp == j_reg) ? ST_PIV : ST_SW_RD;
                else
                    state_next = ST_F_RD;
            end
            ST_SW_RD:   state_next = ST_SW_W1;
            ST_SW_W1:   state_next = ST_SW_W2;
            ST_SW_W2:   state_next = (k_reg == 2'd3) ? ST_PIV : ST_SW_RD;
            ST_PIV:
            begin
                if (bestval_reg == 32'sd0)
                    state_next = ST_OUT_RD;
                else if (j_reg == 2'd3)
                    state_next = ST_V_RD;
                else
                    state_next = ST_D_RD;
            end
            ST_D_RD:    state_next = ST_D_ST;
            ST_D_ST:    state_next = ST_D_WT;
            ST_D_WT:
            begin
                if (drsp.done)
                    state_next = (i_reg == 2'd3) ? ST_F_RD : ST_D_RD;
            end
            ST_V_RD:    state_next = ST_V_SW;
            ST_V_SW:    state_next = (i_reg == 2'd0) ? ST_S_FWR : ST_MAC_RD;
            ST_S_FWR:   state_next = (i_reg == 2'd3) ? ST_B_RD : ST_V_RD;
            ST_B_RD:    state_next = ST_B_LD;
            ST_B_LD:    state_next = (i_reg == 2'd3) ? ST_B_PRD : ST_MAC_RD;
            ST_B_PRD:   state_next = ST_B_DST;
            ST_B_DST:   state_next = ST_B_DWT;
            ST_B_DWT:
            begin
                if (drsp.done)
                begin
                    if (i_reg != 2'd0)
                        state_next = ST_B_RD;
                    else
                        state_next = (r_reg == 2'd3) ? ST_OUT_RD : ST_V_RD;
                end
            end
            ST_OUT_RD:  state_next = ST_OUT_LD;
            ST_OUT_LD:
            begin
                if (out_free)
                    state_next = (n_reg == 4'd15) ? ST_LOAD : ST_OUT_RD;
            end
            default:    state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        t_we  = 1'b0;
        t_wa  = '0;
        t_wd  = s_reg;
        t_raa = '0;
        t_rab = '0;
        v_we  = 1'b0;
        v_wa  = '0;
        v_wd  = s_reg;
        v_raa = '0;
        v_rab = '0;
        dreq.start = 1'b0;
        dreq.a     = t_rda;
        dreq.b     = bestval_reg;
        load_rdy   = 1'b0;
        res.push     = 1'b0;
        res.data     = v_rda;
        res.singular = sing_reg;
        res.last     = (n_reg == 4'd15);
        ma = {t_rda[31], t_rda};
        mb = (phase_reg == PH_FAC) ? {t_rdb[31], t_rdb} : {v_rda[31], v_rda};
        unique case (state_reg)
            ST_LOAD:
            begin
                load_rdy = 1'b1;
                t_we = in_acc;
                t_wa = {n_reg[1:0], n_reg[3:2]};
                t_wd = in_element;
                v_we = in_acc;
                v_wa = n_reg;
                v_wd = (n_reg[3:2] == n_reg[1:0]) ? ONE : 32'sd0;
            end
            ST_F_RD:   t_raa = {i_reg, j_reg};
            ST_MAC_RD:
            begin
                t_raa = {i_reg, k_reg};
                t_rab = {k_reg, j_reg};
                v_raa = {r_reg, k_reg};
            end
            ST_F_WR:
            begin
                t_we = 1'b1;
                t_wa = {i_reg, j_reg};
            end
            ST_CMP1:
            begin
                ma = {1'b0, mag32(s_reg)};
                mb = {1'b0, rowmax_reg[best_reg]};
            end
            ST_CMP2:
            begin
                ma = {1'b0, mag32(bestval_reg)};
                mb = {1'b0, rowmax_reg[i_reg]};
            end
            ST_SW_RD:
            begin
                t_raa = {best_reg, k_reg};
                t_rab = {j_reg, k_reg};
            end
            ST_SW_W1:
            begin
                t_we = 1'b1;
                t_wa = {j_reg, k_reg};
                t_wd = t_rda;
            end
            ST_SW_W2:
            begin
                t_we = 1'b1;
                t_wa = {best_reg, k_reg};
            end
            ST_D_RD:   t_raa = {i_reg, j_reg};
            ST_D_ST:   dreq.start = 1'b1;
            ST_D_WT:
            begin
                t_we = drsp.done;
                t_wa = {i_reg, j_reg};
                t_wd = drsp.q;
            end
            ST_V_RD:
            begin
                v_raa = {r_reg, perm_reg[i_reg]};
                v_rab = {r_reg, i_reg};
            end
            ST_V_SW:
            begin
                v_we = 1'b1;
                v_wa = {r_reg, perm_reg[i_reg]};
                v_wd = v_rdb;
            end
            ST_S_FWR:
            begin
                v_we = 1'b1;
                v_wa = {r_reg, i_reg};
            end
            ST_B_RD:   v_raa = {r_reg, i_reg};
            ST_B_PRD:  t_raa = {i_reg, i_reg};
            ST_B_DST:
            begin
                dreq.start = 1'b1;
                dreq.a     = s_reg;
                dreq.b     = t_rda;
            end
            ST_B_DWT:
            begin
                v_we = drsp.done;
                v_wa = {r_reg, i_reg};
                v_wd = drsp.q;
            end
            ST_OUT_RD: v_raa = n_reg;
            ST_OUT_LD:
            begin
                v_raa    = n_reg;
                res.push = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            n_reg     <= '0;
            sing_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_LOAD && in_acc)
            begin
                n_reg    <= n_reg + 4'd1;
                sing_reg <= 1'b0;
            end
            if (state_reg == ST_CHK && zero_row)
                sing_reg <= 1'b1;
            if (state_reg == ST_PIV && bestval_reg == 32'sd0)
                sing_reg <= 1'b1;
            if (state_reg == ST_OUT_LD && out_free)
                n_reg <= n_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_LOAD:
            begin
                // row maxima of the transposed matrix follow the loaded columns
                if (in_acc)
                begin
                    if (n_reg[3:2] == 2'd0 || in_mag > rowmax_reg[n_reg[1:0]])
                        rowmax_reg[n_reg[1:0]] <= in_mag;
                end
            end
            ST_CHK:
            begin
                j_reg <= '0;
                i_reg <= '0;
            end
            ST_F_LD:
            begin
                s_reg     <= t_rda;
                k_reg     <= '0;
                kmax_reg  <= kmin;
                phase_reg <= PH_FAC;
            end
            ST_MAC_MUL: preg <= prod;
            ST_MAC_ACC:
            begin
                s_reg <= acc;
                k_reg <= k_reg + 2'd1;
            end
            ST_F_WR:
            begin
                k_reg <= '0;
                if (i_reg == j_reg)
                begin
                    best_reg    <= j_reg;
                    bestval_reg <= s_reg;
                end
                if (i_reg <= j_reg && i_reg != 2'd3)
                    i_reg <= i_reg + 2'd1;
            end
            ST_CMP1:    preg <= prod;
            ST_CMP2:
            begin
                hold_reg <= preg[63:0];
                preg     <= prod;
            end
            ST_CMP3:
            begin
                k_reg <= '0;
                if (ge)
                begin
                    best_reg    <= i_reg;
                    bestval_reg <= s_reg;
                end
                if (i_reg != 2'd3)
                    i_reg <= i_reg + 2'd1;
            end
            ST_SW_W1:   s_reg <= t_rdb;
            ST_SW_W2:   k_reg <= k_reg + 2'd1;
            ST_PIV:
            begin
                perm_reg[j_reg] <= best_reg;
                if (best_reg != j_reg)
                begin
                    rowmax_reg[j_reg]    <= rowmax_reg[best_reg];
                    rowmax_reg[best_reg] <= rowmax_reg[j_reg];
                end
                i_reg <= j_reg + 2'd1;
                r_reg <= '0;
            end
            ST_D_WT:
            begin
                if (drsp.done)
                begin
                    if (i_reg == 2'd3)
                    begin
                        j_reg <= j_reg + 2'd1;
                        i_reg <= '0;
                    end
                    else
                        i_reg <= i_reg + 2'd1;
                end
            end
            ST_V_SW:
            begin
                s_reg     <= v_rda;
                k_reg     <= '0;
                kmax_reg  <= i_reg;
                phase_reg <= PH_FWD;
            end
            ST_S_FWR:   if (i_reg != 2'd3) i_reg <= i_reg + 2'd1;
            ST_B_LD:
            begin
                s_reg     <= v_rda;
                k_reg     <= i_reg + 2'd1;
                phase_reg <= PH_BWD;
            end
            ST_B_DWT:
            begin
                if (drsp.done)
                begin
                    if (i_reg == 2'd0)
                        r_reg <= r_reg + 2'd1;
                    else
                        i_reg <= i_reg - 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- src/matrix_inverse_4x4_lu_top.sv -----
// 4x4 fixed point matrix inverter top level with output word register
//
//   channel      dir   word fields
//   element_ch   in    element (s32)
//   inverse_ch   out   inverse_element (s32), singular, last
//
// sixteen input words are taken one a cycle while no result word is pending,
// then the block works alone: 22 divides in the shared restoring divider
// dominate, plus a read, multiply and accumulate state per multiply-subtract
// step. result words are read and loaded one at a time. no input is taken
// while a matrix is in work or being emitted; the output word holds under
// back-pressure. reset clears the load count and sequencer.
`timescale 1ns / 1ps
module matrix_inverse_4x4_lu_top
    import lui_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    lui_elem_if.sink   element_ch,
    lui_inv_if.source  inverse_ch
);
    logic              load_rdy;
    logic              in_acc;
    logic              out_free;
    res_word_t         res;
    div_req_t          dreq;
    div_rsp_t          drsp;

    logic              ovalid_reg;
    logic signed [31:0] odata_reg;
    logic              osing_reg;
    logic              olast_reg;

    assign element_ch.ready = load_rdy && !ovalid_reg;
    assign in_acc   = element_ch.valid && element_ch.ready;
    assign out_free = !ovalid_reg || inverse_ch.ready;

    lui_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_acc     (in_acc),
        .in_element (element_ch.element),
        .load_rdy   (load_rdy),
        .out_free   (out_free),
        .res        (res),
        .dreq       (dreq),
        .drsp       (drsp)
    );

    lui_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (res.push)
            ovalid_reg <= 1'b1;
        else if (inverse_ch.ready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res.push)
        begin
            odata_reg <= res.data;
            osing_reg <= res.singular;
            olast_reg <= res.last;
        end
    end

    assign inverse_ch.valid           = ovalid_reg;
    assign inverse_ch.inverse_element = odata_reg;
    assign inverse_ch.singular        = osing_reg;
    assign inverse_ch.last            = olast_reg;

endmodule

// ----- src/lui_checker.sv -----
// port-level checks for the inverter, bound to the top level
`timescale 1ns / 1ps
module lui_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_data,
    input logic        out_last
);
    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result word is pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result word changed");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid)
        else $error("word after the last of a run");

    a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> !in_ready)
        else $error("input opened in the middle of a result run");

    a_in_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result word right after an input word");

endmodule

bind matrix_inverse_4x4_lu_top lui_checker u_lui_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (element_ch.valid),
    .in_ready  (element_ch.ready),
    .out_valid (inverse_ch.valid),
    .out_ready (inverse_ch.ready),
    .out_data  (inverse_ch.inverse_element),
    .out_last  (inverse_ch.last)
);
